[sv/lpfr_pkg.sv]
// Shared constants, types and helpers of the length-prefixed frame receiver.
package lpfr_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned LEN_W      = 21;
    localparam int unsigned EVENT_W    = 3;
    localparam int unsigned LENGTH_CHARS = 6;

    localparam logic [BYTE_W-1:0] START_BYTE  = 8'h24;
    localparam logic [LEN_W-1:0]  LENGTH_INIT = LEN_W'(200);

    typedef enum logic [EVENT_W-1:0] {
        EV_IDLE  = 3'd0,
        EV_START = 3'd1,
        EV_LEN   = 3'd2,
        EV_DATA  = 3'd3,
        EV_GOOD  = 3'd4,
        EV_BAD   = 3'd5
    } t_event;

    function automatic logic [3:0] digit_of(input logic [BYTE_W-1:0] b);
        logic [3:0] d;
        d = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            d = 4'(b - 8'h30);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            d = 4'(b - 8'h57);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            d = 4'(b - 8'h37);
        end
        return d;
    endfunction

endpackage

[sv/lpfr_if.sv]
// Request channels of the frame receiver: received bytes in, events out.
interface lpfr_byte_if import lpfr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lpfr_event_if import lpfr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [EVENT_W-1:0] event_res;
    logic [BYTE_W-1:0]  data_byte;
    logic [LEN_W-1:0]   payload_offset;
    logic [LEN_W-1:0]   frame_length;
    logic [BYTE_W-1:0]  checksum_value;

    modport source (output valid, output event_res, output data_byte, output payload_offset,
                    output frame_length, output checksum_value, input ready);
    modport sink   (input valid, input event_res, input data_byte, input payload_offset,
                    input frame_length, input checksum_value, output ready);
endinterface

[sv/length_prefixed_frame_receiver.sv]
// Top level of the length-prefixed frame receiver with XOR checksum.
//
//   port   dir  payload                                                    width
//   i_rx   in   rx_byte                                                    8
//   o_evt  out  event_res, data_byte, payload_offset, frame_length,        3/8/21/21/8
//               checksum_value
//
// One byte request is taken every cycle unless o_evt stalls; each yields one event
// through the input register, then the parse logic into the result register.
// Synchronous active-low reset clears the parse state; length starts at 200.
// A stall on o_evt backs up through both registers to i_rx.ready in the same cycle.
module length_prefixed_frame_receiver import lpfr_pkg::*; #(
    parameter int unsigned LEN_CHARS = LENGTH_CHARS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    lpfr_byte_if.sink    i_rx,
    lpfr_event_if.source o_evt
);

    lpfr_byte_if u_mid ();

    lpfr_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (i_rx),
        .o_byte  (u_mid.source)
    );

    lpfr_core #(
        .LEN_CHARS (LEN_CHARS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (u_mid.sink),
        .o_evt   (o_evt)
    );

endmodule

[sv/lpfr_in_reg.sv]
// Input register stage: holds one received byte request for the frame core.
module lpfr_in_reg import lpfr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lpfr_byte_if.sink   i_byte,
    lpfr_byte_if.source o_byte
);

    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              n_valid;

    assign i_byte.ready   = !r_valid || o_byte.ready;
    assign o_byte.valid   = r_valid;
    assign o_byte.rx_byte = r_byte;

    always_comb begin
        n_valid = r_valid;
        if (i_byte.ready) begin
            n_valid = i_byte.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (i_byte.valid && i_byte.ready) begin
            r_byte <= i_byte.rx_byte;
        end
    end

endmodule

[sv/lpfr_core.sv]
// Frame core: parse state, per-byte event decode and the result register.
module lpfr_core import lpfr_pkg::*; #(
    parameter int unsigned LEN_CHARS = LENGTH_CHARS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    lpfr_byte_if.sink    i_byte,
    lpfr_event_if.source o_evt
);

    logic               r_in_frame;
    logic [LEN_W-1:0]   r_position;
    logic [LEN_W-1:0]   r_length_value;
    logic               r_length_ended;
    logic [BYTE_W-1:0]  r_running_xor;

    logic               r_out_valid;
    t_event             r_event;
    logic [BYTE_W-1:0]  r_data_byte;
    logic [LEN_W-1:0]   r_offset;
    logic [LEN_W-1:0]   r_flen;
    logic [BYTE_W-1:0]  r_csum;

    logic               n_in_frame;
    logic [LEN_W-1:0]   n_position;
    logic [LEN_W-1:0]   n_length_value;
    logic               n_length_ended;
    logic [BYTE_W-1:0]  n_running_xor;
    logic               n_out_valid;
    t_event             n_event;
    logic [LEN_W-1:0]   n_offset;
    logic [LEN_W-1:0]   n_flen;
    logic [BYTE_W-1:0]  n_csum;

    logic               take;
    logic [BYTE_W-1:0]  b;
    logic [LEN_W-1:0]   rel_pos;
    logic [BYTE_W-1:0]  xor_next;

    assign i_byte.ready = !r_out_valid || o_evt.ready;
    assign take         = i_byte.valid && i_byte.ready;
    assign b            = i_byte.rx_byte;
    assign rel_pos      = r_position - LEN_W'(LEN_CHARS);
    assign xor_next     = r_running_xor ^ b;

    always_comb begin
        n_in_frame     = r_in_frame;
        n_position     = r_position;
        n_length_value = r_length_value;
        n_length_ended = r_length_ended;
        n_running_xor  = r_running_xor;
        n_event        = EV_IDLE;
        n_offset       = '0;
        n_flen         = '0;
        n_csum         = '0;
        if (b == START_BYTE) begin
            n_in_frame     = 1'b1;
            n_position     = '0;
            n_length_value = '0;
            n_length_ended = 1'b0;
            n_running_xor  = '0;
            n_event        = EV_START;
        end else if (r_in_frame) begin
            if (r_position < LEN_W'(LEN_CHARS)) begin
                if (b == '0) begin
                    n_length_ended = 1'b1;
                end else if (!r_length_ended) begin
                    n_length_value = (r_length_value << 3) + (r_length_value << 1)
                                   + LEN_W'(digit_of(b));
                end
                n_position = r_position + LEN_W'(1);
                n_event    = EV_LEN;
            end else if (rel_pos < r_length_value) begin
                n_running_xor = xor_next;
                n_offset      = rel_pos;
                n_flen        = r_length_value;
                n_csum        = xor_next;
                n_position    = r_position + LEN_W'(1);
                n_event       = EV_DATA;
            end else begin
                n_flen     = r_length_value;
                n_csum     = r_running_xor;
                n_event    = (b == r_running_xor) ? EV_GOOD : EV_BAD;
                n_in_frame = 1'b0;
                n_position = '0;
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (i_byte.ready) begin
            n_out_valid = i_byte.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame     <= 1'b0;
            r_position     <= '0;
            r_length_value <= LENGTH_INIT;
            r_length_ended <= 1'b0;
            r_running_xor  <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (take) begin
                r_in_frame     <= n_in_frame;
                r_position     <= n_position;
                r_length_value <= n_length_value;
                r_length_ended <= n_length_ended;
                r_running_xor  <= n_running_xor;
            end
        end
        if (take) begin
            r_event     <= n_event;
            r_data_byte <= b;
            r_offset    <= n_offset;
            r_flen      <= n_flen;
            r_csum      <= n_csum;
        end
    end

    assign o_evt.valid          = r_out_valid;
    assign o_evt.event_res      = r_event;
    assign o_evt.data_byte      = r_data_byte;
    assign o_evt.payload_offset = r_offset;
    assign o_evt.frame_length   = r_flen;
    assign o_evt.checksum_value = r_csum;

endmodule

[bench/tb_frame_checker.sv]
// Frame receiver checker: watches both channels, predicts each event and compares it.
`timescale 1ns / 1ps
module tb_frame_checker import lpfr_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    lpfr_byte_if   rx_mon,
    lpfr_event_if  evt_mon,
    output int     o_fail_count,
    output int     o_pending,
    output int     o_good_frames,
    output int     o_bad_frames,
    output int     o_payload_bytes
);

    typedef struct packed {
        t_event            ev;
        logic [BYTE_W-1:0] data_byte;
        logic [LEN_W-1:0]  payload_off;
        logic [LEN_W-1:0]  frame_len;
        logic [BYTE_W-1:0] csum;
    } t_frame_event;

    logic              in_frame_q;
    logic [LEN_W-1:0]  pos_q;
    logic [LEN_W-1:0]  len_q;
    logic              len_done_q;
    logic [BYTE_W-1:0] xor_q;
    t_frame_event      expected_events[$];

    function automatic logic [3:0] char_value(input logic [BYTE_W-1:0] c);
        if (c inside {[8'h30:8'h39]}) begin
            return c[3:0];
        end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
            return 4'(c[2:0] + 4'd9);
        end
        return 4'd0;
    endfunction

    task automatic take_byte(input logic [BYTE_W-1:0] b, output t_frame_event r);
        r = '0;
        r.data_byte = b;
        r.ev = EV_IDLE;
        if (b == START_BYTE) begin
            in_frame_q = 1'b1;
            pos_q = '0;
            len_q = '0;
            len_done_q = 1'b0;
            xor_q = '0;
            r.ev = EV_START;
        end else if (in_frame_q) begin
            if (pos_q < LEN_W'(LENGTH_CHARS)) begin
                if (b == 8'h00) begin
                    len_done_q = 1'b1;
                end else if (!len_done_q) begin
                    len_q = LEN_W'(len_q * 10 + char_value(b));
                end
                pos_q = pos_q + 1'b1;
                r.ev = EV_LEN;
            end else if (pos_q - LEN_W'(LENGTH_CHARS) < len_q) begin
                xor_q = xor_q ^ b;
                r.payload_off = pos_q - LEN_W'(LENGTH_CHARS);
                r.frame_len = len_q;
                r.csum = xor_q;
                pos_q = pos_q + 1'b1;
                r.ev = EV_DATA;
            end else begin
                r.frame_len = len_q;
                r.csum = xor_q;
                r.ev = (b == xor_q) ? EV_GOOD : EV_BAD;
                in_frame_q = 1'b0;
                pos_q = '0;
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_frame_event fresh;
        t_frame_event want;
        t_frame_event got;
        if (!i_rst_n) begin
            in_frame_q = 1'b0;
            pos_q = '0;
            len_q = LENGTH_INIT;
            len_done_q = 1'b0;
            xor_q = '0;
            expected_events.delete();
            o_fail_count = 0;
            o_good_frames = 0;
            o_bad_frames = 0;
            o_payload_bytes = 0;
        end else begin
            if (rx_mon.valid && rx_mon.ready) begin
                take_byte(rx_mon.rx_byte, fresh);
                expected_events.push_back(fresh);
            end
            if (evt_mon.valid && evt_mon.ready) begin
                got.ev = t_event'(evt_mon.event_res);
                got.data_byte = evt_mon.data_byte;
                got.payload_off = evt_mon.payload_offset;
                got.frame_len = evt_mon.frame_length;
                got.csum = evt_mon.checksum_value;
                if (expected_events.size() == 0) begin
                    if (o_fail_count < 10) begin
                        $display({"frame_check: unexpected event ",
                                  "ev=%0d byte=%02h off=%0d len=%0d csum=%02h"},
                                 got.ev, got.data_byte, got.payload_off, got.frame_len,
                                 got.csum);
                    end
                    o_fail_count++;
                end else begin
                    want = expected_events.pop_front();
                    if (got !== want) begin
                        if (o_fail_count < 10) begin
                            $display("frame_check: mismatch at %0t", $realtime);
                            $display("  expected ev=%0d byte=%02h off=%0d len=%0d csum=%02h",
                                     want.ev, want.data_byte, want.payload_off, want.frame_len,
                                     want.csum);
                            $display("  actual   ev=%0d byte=%02h off=%0d len=%0d csum=%02h",
                                     got.ev, got.data_byte, got.payload_off, got.frame_len,
                                     got.csum);
                        end
                        o_fail_count++;
                    end
                    if (want.ev == EV_GOOD) o_good_frames++;
                    if (want.ev == EV_BAD) o_bad_frames++;
                    if (want.ev == EV_DATA) o_payload_bytes++;
                end
            end
        end
        o_pending = expected_events.size();
    end

endmodule

[bench/tb_top.sv]
// Top of the frame receiver bench: clock, reset, byte stimulus, output stalls and verdict.
`timescale 1ns / 1ps
module tb_top;
    import lpfr_pkg::*;

    localparam int PHASE_REQUESTS = 70;
    localparam int LONG_HOLD      = 300;
    localparam int DRAIN_CYCLES   = 20;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   send_idle_pct;
    int   stall_pct;
    logic long_hold_req;
    int   sent_count;
    int   fail_count;
    int   pending;
    int   good_frames;
    int   bad_frames;
    int   payload_bytes;

    int   idle_by_phase[4]  = '{0, 67, 0, 34};
    int   stall_by_phase[4] = '{0, 0, 67, 34};

    logic [BYTE_W-1:0] directed_bytes[26] = '{
        8'h00, 8'hFF,
        START_BYTE, 8'h00, "Z", "9", "x", "1", 8'h01,
        START_BYTE, "f", "F", "f", "F", "f", "F", 8'h5A,
        START_BYTE, "0", "0", "0", "0", "0", "1", 8'hA5, 8'hA5
    };

    lpfr_byte_if  rx_ch();
    lpfr_event_if evt_ch();

    length_prefixed_frame_receiver dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_ch),
        .o_evt   (evt_ch)
    );

    tb_frame_checker u_frame_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .rx_mon          (rx_ch),
        .evt_mon         (evt_ch),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_good_frames   (good_frames),
        .o_bad_frames    (bad_frames),
        .o_payload_bytes (payload_bytes)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [BYTE_W-1:0] non_start_byte();
        logic [BYTE_W-1:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == START_BYTE) b = 8'($urandom_range(0, 8'h23));
        return b;
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            rx_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        rx_ch.valid <= 1'b1;
        rx_ch.rx_byte <= b;
        @(posedge i_clk);
        while (!rx_ch.ready) @(posedge i_clk);
        sent_count++;
    endtask

    task automatic send_frame();
        logic [BYTE_W-1:0] bytes[$];
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] c;
        int sig;
        int pick;
        int flen;
        int d;
        int cut;
        bit zero_term;
        bytes.push_back(START_BYTE);
        pick = $urandom_range(0, 9);
        sig = (pick == 0) ? 0 : (pick == 9) ? 2 : 1;
        zero_term = 1'($urandom_range(0, 1));
        flen = 0;
        if (!zero_term) begin
            repeat (LENGTH_CHARS - sig) bytes.push_back("0");
        end
        repeat (sig) begin
            d = $urandom_range(0, 15);
            flen = flen * 10 + d;
            if (d < 10) begin
                bytes.push_back(8'(8'h30 + d));
            end else begin
                bytes.push_back(8'(($urandom_range(0, 1) ? 8'h61 : 8'h41) + d - 10));
            end
        end
        if (zero_term) begin
            bytes.push_back(8'h00);
            repeat (LENGTH_CHARS - sig - 1) bytes.push_back(non_start_byte());
        end
        sum = '0;
        repeat (flen) begin
            c = non_start_byte();
            sum ^= c;
            bytes.push_back(c);
        end
        if ($urandom_range(0, 4) == 0) sum ^= 8'($urandom_range(1, 255));
        bytes.push_back(sum);
        if ($urandom_range(0, 9) == 0) begin
            cut = $urandom_range(1, bytes.size() - 1);
            bytes = bytes[0:cut-1];
        end
        foreach (bytes[i]) send_byte(bytes[i]);
    endtask

    initial begin
        evt_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                evt_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                long_hold_req = 1'b0;
            end else begin
                evt_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    initial begin
        int target;
        i_rst_n <= 1'b0;
        rx_ch.valid <= 1'b0;
        rx_ch.rx_byte <= '0;
        long_hold_req = 1'b0;
        send_idle_pct = 0;
        stall_pct = 0;
        sent_count = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct = idle_by_phase[phase];
            stall_pct = stall_by_phase[phase];
            if (phase == 0) long_hold_req = 1'b1;
            target = sent_count + PHASE_REQUESTS;
            while (sent_count < target) begin
                if ($urandom_range(0, 9) < 3) begin
                    repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
                end
                send_frame();
            end
        end
        rx_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("tb_top: %0d byte requests over four idle/stall phases, one long output hold",
                 sent_count);
        $display("tb_top: %0d good frames, %0d checksum errors, %0d payload bytes checked",
                 good_frames, bad_frames, payload_bytes);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule

[length_prefixed_frame_receiver.f]
sv/lpfr_pkg.sv
sv/lpfr_if.sv
sv/lpfr_in_reg.sv
sv/lpfr_core.sv
sv/length_prefixed_frame_receiver.sv
bench/tb_frame_checker.sv
bench/tb_top.sv
